// ----- rtl/bba_pkg.sv -----
// Shared types and constants of the buddy block allocator.
// Used by bba_ctrl, bba_dp and the top level; depends on nothing.
package bba_pkg;

  localparam int ENT_W = 6;
  localparam int ORD_W = 4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] request_bytes;
    logic [15:0] free_offset;
  } bba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_offset;
    logic [3:0]  block_order;
    logic [16:0] threshold_bytes;
  } bba_res_t;

  typedef struct packed {
    logic             head;
    logic             alloc;
    logic [ORD_W-1:0] ord;
  } bba_ent_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_SRD, S_SEV, S_ACHK, S_SPLIT, S_AWR,
    S_FRD, S_FEV, S_MW1, S_MRD, S_MEV, S_MW0, S_RESP
  } bba_state_t;

  typedef struct packed {
    bba_state_t op;
    logic       accept;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dec_fail;
    logic is_free;
    logic scan_end;
    logic found;
    logic split_done;
    logic ent_bad;
    logic at_top;
    logic bud_match;
  } bba_stat_t;

endpackage

// ----- rtl/bba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module bba_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/bba_ctrl.sv -----
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg; drives the datapath through bba_cmd_t.
module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t  cmd,
  output logic               busy
);
  import bba_pkg::*;

  bba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:   if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_DEC;
      S_DEC: begin
        if (stat.dec_fail) state_nxt = S_RESP;
        else if (stat.is_free) state_nxt = S_FRD;
        else state_nxt = S_SRD;
      end
      S_SRD:   state_nxt = S_SEV;
      S_SEV: begin
        if (!stat.scan_end) state_nxt = S_SRD;
        else if (stat.is_free) state_nxt = S_RESP;
        else state_nxt = S_ACHK;
      end
      S_ACHK:  state_nxt = stat.found ? S_SPLIT : S_RESP;
      S_SPLIT: if (stat.split_done) state_nxt = S_AWR;
      S_AWR:   state_nxt = S_RESP;
      S_FRD:   state_nxt = S_FEV;
      S_FEV:   state_nxt = stat.ent_bad ? S_RESP : S_MW1;
      S_MW1:   state_nxt = stat.at_top ? S_SRD : S_MRD;
      S_MRD:   state_nxt = S_MEV;
      S_MEV:   state_nxt = stat.bud_match ? S_MW0 : S_SRD;
      S_MW0:   state_nxt = S_MW1;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    cmd.op     = state_r;
    cmd.accept = (state_r == S_IDLE) && start;
    busy       = (state_r != S_IDLE);
  end
endmodule

// ----- rtl/bba_dp.sv -----
// Datapath of the buddy block allocator: unit table, scan, split and merge.
// Depends on bba_pkg and bba_ram; steered by bba_ctrl.
module bba_dp #(
  parameter int NUM_ORDERS      = 11,
  parameter int MIN_BLOCK_BYTES = 32,
  parameter int HEADER_BYTES    = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bba_pkg::bba_cmd_t  cmd,
  input  bba_pkg::bba_req_t  in_req,
  output bba_pkg::bba_stat_t stat,
  output logic               out_valid,
  output bba_pkg::bba_res_t  out_res
);
  import bba_pkg::*;

  localparam int TOP = NUM_ORDERS - 1;
  localparam int AW  = NUM_ORDERS;
  localparam int NU  = 1 << AW;
  localparam int TW  = $clog2(MIN_BLOCK_BYTES) + NUM_ORDERS + 2;
  localparam logic [AW:0]   ONE_S = 1;
  localparam logic [AW-1:0] ONE_A = 1;
  localparam logic [AW-1:0] MID_A = ONE_A << TOP;
  localparam logic [ORD_W-1:0] TOP_O = ORD_W'(TOP);
  localparam logic [TW-1:0] MIN_T = TW'(MIN_BLOCK_BYTES);

  bba_req_t         req_r;
  logic [AW:0]      clr_r, scan_r;
  logic [AW-1:0]    u_r, best_u_r;
  logic [ORD_W-1:0] want_r, best_ord_r, j_r, ord_r, max_ord_r;
  logic             found_r, maxv_r;
  logic [1:0]       status_r;
  logic [15:0]      res_off_r;
  logic [3:0]       res_ord_r;
  logic [TW-1:0]    thr_r, thr_nxt;
  logic             out_valid_r;
  bba_res_t         out_res_r;

  logic             we;
  logic [AW-1:0]    waddr, raddr, bud, hi_a, lo_a;
  bba_ent_t         wdata, rent;
  logic [ENT_W-1:0] rdata;

  logic [16:0]      need, offw, hdrw, startw;
  logic [ORD_W-1:0] want_c;
  logic             fits, too_large, bad_off;
  logic [AW:0]      step, scan_sum;
  logic             take_best;

  bba_ram #(.WIDTH(ENT_W), .DEPTH(NU)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign rent = bba_ent_t'(rdata);
  assign bud  = u_r ^ (ONE_A << ord_r);
  assign hi_a = (bud > u_r) ? bud : u_r;
  assign lo_a = (bud > u_r) ? u_r : bud;

  always_comb begin
    need   = 17'(req_r.request_bytes) + 17'(HEADER_BYTES);
    fits   = 1'b0;
    want_c = '0;
    for (int w = NUM_ORDERS - 1; w >= 0; w--) begin
      if ((MIN_T << w) >= TW'(need)) begin
        fits   = 1'b1;
        want_c = ORD_W'(w);
      end
    end
    too_large = (TW'(need) > thr_r) || !fits;
    offw      = 17'(req_r.free_offset);
    hdrw      = 17'(HEADER_BYTES);
    startw    = offw - hdrw;
    bad_off   = (offw < hdrw) || ((startw % 17'(MIN_BLOCK_BYTES)) != 17'd0) ||
                ((startw / 17'(MIN_BLOCK_BYTES)) >= 17'(NU));
  end

  always_comb begin
    step      = rent.head ? (ONE_S << rent.ord) : ONE_S;
    scan_sum  = scan_r + step;
    take_best = rent.head && !rent.alloc && (rent.ord >= want_r) &&
                (!found_r || (rent.ord < best_ord_r));
  end

  always_comb begin
    we    = 1'b0;
    waddr = scan_r[AW-1:0];
    wdata = '0;
    raddr = scan_r[AW-1:0];
    case (cmd.op)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r[AW-1:0];
        if (clr_r[AW-1:0] == '0 || clr_r[AW-1:0] == MID_A) begin
          wdata = '{head: 1'b1, alloc: 1'b0, ord: TOP_O};
        end
      end
      S_SPLIT: begin
        we    = (j_r != want_r);
        waddr = best_u_r + (ONE_A << (j_r - 4'd1));
        wdata = '{head: 1'b1, alloc: 1'b0, ord: j_r - 4'd1};
      end
      S_AWR: begin
        we    = 1'b1;
        waddr = best_u_r;
        wdata = '{head: 1'b1, alloc: 1'b1, ord: want_r};
      end
      S_MW1: begin
        we    = 1'b1;
        waddr = u_r;
        wdata = '{head: 1'b1, alloc: 1'b0, ord: ord_r};
      end
      S_MW0: begin
        we    = 1'b1;
        waddr = hi_a;
      end
      S_FRD:   raddr = u_r;
      S_MRD:   raddr = bud;
      default: raddr = scan_r[AW-1:0];
    endcase
  end

  always_comb begin
    thr_nxt = thr_r;
    if (req_r.req_type == REQ_FREE && status_r == ST_OK && maxv_r) begin
      thr_nxt = MIN_T << (5'(max_ord_r) + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      thr_r       <= MIN_T << TOP;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == S_RESP);
      case (cmd.op)
        S_CLR:   clr_r <= clr_r + ONE_S;
        S_RESP:  thr_r <= thr_nxt;
        default: clr_r <= clr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      S_IDLE: if (cmd.accept) req_r <= in_req;
      S_DEC: begin
        scan_r    <= '0;
        found_r   <= 1'b0;
        maxv_r    <= 1'b0;
        max_ord_r <= '0;
        res_off_r <= '0;
        res_ord_r <= '0;
        want_r    <= (req_r.req_type == REQ_FREE) ? '0 : want_c;
        u_r       <= AW'(startw / 17'(MIN_BLOCK_BYTES));
        if (req_r.req_type == REQ_FREE) begin
          status_r <= bad_off ? ST_BAD_FREE : ST_OK;
        end else begin
          status_r <= too_large ? ST_TOO_LARGE : ST_OK;
        end
      end
      S_SEV: begin
        scan_r <= scan_sum;
        if (take_best) begin
          found_r    <= 1'b1;
          best_ord_r <= rent.ord;
          best_u_r   <= scan_r[AW-1:0];
        end
        if (rent.head && !rent.alloc && rent.ord != '0 &&
            (!maxv_r || rent.ord > max_ord_r)) begin
          maxv_r    <= 1'b1;
          max_ord_r <= rent.ord;
        end
      end
      S_ACHK: begin
        j_r <= best_ord_r;
        if (!found_r) status_r <= ST_NO_SPACE;
      end
      S_SPLIT: if (j_r != want_r) j_r <= j_r - 4'd1;
      S_AWR: begin
        res_off_r <= 16'(32'(best_u_r) * 32'(MIN_BLOCK_BYTES) + 32'(HEADER_BYTES));
        res_ord_r <= want_r;
      end
      S_FEV: begin
        ord_r <= rent.ord;
        if (!rent.head || !rent.alloc) status_r <= ST_BAD_FREE;
        else res_ord_r <= rent.ord;
      end
      S_MW0: begin
        u_r   <= lo_a;
        ord_r <= ord_r + 4'd1;
      end
      S_RESP: begin
        out_res_r.status          <= status_r;
        out_res_r.result_offset   <= res_off_r;
        out_res_r.block_order     <= res_ord_r;
        out_res_r.threshold_bytes <= 17'(thr_nxt);
      end
      default: u_r <= u_r;
    endcase
  end

  always_comb begin
    stat.clr_last   = (clr_r == ONE_S << AW) || (clr_r[AW-1:0] == {AW{1'b1}});
    stat.dec_fail   = (req_r.req_type == REQ_FREE) ? bad_off : too_large;
    stat.is_free    = (req_r.req_type == REQ_FREE);
    stat.scan_end   = scan_sum[AW];
    stat.found      = found_r;
    stat.split_done = (j_r == want_r);
    stat.ent_bad    = !rent.head || !rent.alloc;
    stat.at_top     = (ord_r >= TOP_O);
    stat.bud_match  = rent.head && !rent.alloc && (rent.ord == ord_r);
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
endmodule

// ----- rtl/buddy_block_allocator.sv -----
// Buddy block allocator, top level: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_dp and bba_ram.
//
// Usage:
//   A request (allocate or free) is taken at a clock edge with start high and
//   busy low. busy stays high until the answer is out; one request at a time.
//   Each request yields exactly one answer on out_res, marked by a one-cycle
//   out_valid strobe in the first cycle with busy low. The receiver cannot stall.
//   An allocate walks every block of the heap once through the registered
//   unit-table read port, then splits the chosen block level by level. A
//   free reads its entry, merges with its buddy level by level, then walks
//   the heap once to refresh the threshold. The block walk over the single
//   read port dominates the response time. Requests rejected at decode go
//   straight to the answer; a free of an entry that is not an allocated
//   block start answers once that entry has been read.
//   After reset the block sweeps all 2^NUM_ORDERS entries of the unit table
//   (2048 by default), one entry a cycle, with busy high, then goes idle.
module buddy_block_allocator #(
  parameter int NUM_ORDERS      = 11,
  parameter int MIN_BLOCK_BYTES = 32,
  parameter int HEADER_BYTES    = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bba_pkg::bba_req_t in_req,
  output logic              out_valid,
  output bba_pkg::bba_res_t out_res
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  bba_dp #(
    .NUM_ORDERS(NUM_ORDERS), .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_req(in_req), .stat(stat),
    .out_valid(out_valid), .out_res(out_res)
  );

`ifndef SYNTH
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("answer while busy");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != ST_OK) |->
    (out_res.result_offset == 16'd0 && out_res.block_order == 4'd0))
    else $error("failed request carries data");
`endif
endmodule
